// ----- sv/trss_pkg.sv -----
// shared types, constants and codes for the thread scheduler
`timescale 1ns / 1ps
`default_nettype none
package trss_pkg;

    localparam int MAX_THREADS = 16;
    localparam int SLOT_W      = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int ID_W        = 32;
    localparam int WOKEN_W     = 7;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [ID_W-1:0]   id_t;
    typedef logic [2:0]        status_t;

    localparam slot_t IDLE_SLOT = slot_t'(1);

    localparam status_t ST_FREE     = 3'd0;
    localparam status_t ST_READY    = 3'd1;
    localparam status_t ST_RUNNING  = 3'd2;
    localparam status_t ST_SLEEPING = 3'd3;
    localparam status_t ST_BLOCKED  = 3'd4;
    localparam status_t ST_ZOMBIE   = 3'd5;

    localparam logic [1:0] ACT_CREATE   = 2'd0;
    localparam logic [1:0] ACT_UNBLOCK  = 2'd1;
    localparam logic [1:0] ACT_SCHEDULE = 2'd2;
    localparam logic [1:0] ACT_TICK     = 2'd3;

    localparam logic [1:0] DISP_YIELD = 2'd0;
    localparam logic [1:0] DISP_SLEEP = 2'd1;
    localparam logic [1:0] DISP_BLOCK = 2'd2;
    localparam logic [1:0] DISP_EXIT  = 2'd3;

    localparam logic [1:0] RES_OK    = 2'd0;
    localparam logic [1:0] RES_FULL  = 2'd1;
    localparam logic [1:0] RES_BADID = 2'd2;

    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_CREATE    = 4'd2;
    localparam logic [3:0] OP_UNBLOCK   = 4'd3;
    localparam logic [3:0] OP_DISP      = 4'd4;
    localparam logic [3:0] OP_ZOMBIE    = 4'd5;
    localparam logic [3:0] OP_PICK      = 4'd6;
    localparam logic [3:0] OP_LEAVE     = 4'd7;
    localparam logic [3:0] OP_ENTER     = 4'd8;
    localparam logic [3:0] OP_TICK_INIT = 4'd9;
    localparam logic [3:0] OP_WAKE      = 4'd10;
    localparam logic [3:0] OP_COMPACT   = 4'd11;
    localparam logic [3:0] OP_OUT       = 4'd12;

    typedef struct packed {
        logic [3:0] op;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic idx_zero;
        logic idx_max;
        logic idx_top;
        logic switch_flag;
        logic sleep_empty;
    } stat_t;

endpackage
`default_nettype wire

// ----- sv/trss_dp.sv -----
// scheduler datapath: slot table, ready fifo, sleep list and result registers
`timescale 1ns / 1ps
`default_nettype none
module trss_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire trss_pkg::cmd_t  cmd,
    output trss_pkg::stat_t      stat,
    input  wire logic [1:0]      action,
    input  wire logic [31:0]     target_id,
    input  wire logic [1:0]      disposition,
    input  wire logic [31:0]     sleep_ticks,
    input  wire logic [31:0]     now_ticks,
    output logic [1:0]           result_code,
    output logic [31:0]          thread_id,
    output logic [31:0]          running_id,
    output logic [6:0]           woken_count
);
    import trss_pkg::*;

    status_t status_reg [MAX_THREADS];
    status_t status_next [MAX_THREADS];
    id_t     id_reg [MAX_THREADS];
    id_t     id_next [MAX_THREADS];
    id_t     wake_reg [MAX_THREADS];
    id_t     wake_next [MAX_THREADS];
    slot_t   rfifo_reg [MAX_THREADS];
    slot_t   rfifo_next [MAX_THREADS];
    slot_t   slist_reg [MAX_THREADS];
    slot_t   slist_next [MAX_THREADS];

    logic [MAX_THREADS-1:0] wmask_reg, wmask_next;
    slot_t   head_reg, head_next;
    cnt_t    rcnt_reg, rcnt_next;
    cnt_t    scnt_reg, scnt_next;
    cnt_t    kept_reg, kept_next;
    slot_t   cur_reg, cur_next;
    slot_t   nxt_reg, nxt_next;
    logic    switch_reg, switch_next;
    slot_t   idx_reg, idx_next;
    id_t     next_id_reg, next_id_next;
    id_t     run_id_reg, run_id_next;

    logic [1:0]  act_reg;
    id_t         target_reg;
    logic [1:0]  disp_reg;
    id_t         ticks_reg;
    id_t         now_reg;

    logic [1:0]  code_reg, code_next;
    id_t         tid_reg, tid_next;
    logic [WOKEN_W-1:0] woken_reg, woken_next;

    logic [1:0]  res_code_reg;
    id_t         res_tid_reg;
    id_t         res_run_reg;
    logic [WOKEN_W-1:0] res_woken_reg;

    slot_t   addr;
    status_t a_status;
    id_t     a_id;
    id_t     a_wake;
    slot_t   tail;
    slot_t   pick;
    logic    hit;

    function automatic slot_t wrap_add(slot_t base, cnt_t off);
        logic [CNT_W:0] sum;
        sum = {1'b0, {(CNT_W-SLOT_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W+1)'(MAX_THREADS))
            sum = sum - (CNT_W+1)'(MAX_THREADS);
        return sum[SLOT_W-1:0];
    endfunction

    always_comb
    begin
        case (cmd.op)
            OP_DISP, OP_PICK, OP_LEAVE: addr = cur_reg;
            OP_ENTER:                   addr = nxt_reg;
            OP_WAKE:                    addr = slist_reg[idx_reg];
            default:                    addr = idx_reg;
        endcase
    end

    assign a_status = status_reg[addr];
    assign a_id     = id_reg[addr];
    assign a_wake   = wake_reg[addr];
    assign tail     = wrap_add(head_reg, rcnt_reg);

    always_comb
    begin
        status_next  = status_reg;
        id_next      = id_reg;
        wake_next    = wake_reg;
        rfifo_next   = rfifo_reg;
        slist_next   = slist_reg;
        wmask_next   = wmask_reg;
        head_next    = head_reg;
        rcnt_next    = rcnt_reg;
        scnt_next    = scnt_reg;
        kept_next    = kept_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        switch_next  = switch_reg;
        idx_next     = idx_reg;
        next_id_next = next_id_reg;
        run_id_next  = run_id_reg;
        code_next    = code_reg;
        tid_next     = tid_reg;
        woken_next   = woken_reg;
        hit          = 1'b0;
        pick         = IDLE_SLOT;
        case (cmd.op)
            OP_LOAD:
            begin
                idx_next   = '0;
                tid_next   = '0;
                woken_next = '0;
                case (action)
                    ACT_CREATE:  code_next = RES_FULL;
                    ACT_UNBLOCK: code_next = RES_BADID;
                    default:     code_next = RES_OK;
                endcase
            end
            OP_CREATE:
            begin
                idx_next = idx_reg + slot_t'(1);
                if (a_status == ST_FREE)
                begin
                    hit                  = 1'b1;
                    id_next[idx_reg]     = next_id_reg;
                    status_next[idx_reg] = ST_READY;
                    wake_next[idx_reg]   = '0;
                    if (rcnt_reg < cnt_t'(MAX_THREADS))
                    begin
                        rfifo_next[tail] = idx_reg;
                        rcnt_next        = rcnt_reg + cnt_t'(1);
                    end
                    tid_next     = next_id_reg;
                    next_id_next = next_id_reg + id_t'(1);
                    code_next    = RES_OK;
                end
            end
            OP_UNBLOCK:
            begin
                idx_next = idx_reg + slot_t'(1);
                if (a_status != ST_FREE && a_id == target_reg)
                begin
                    hit = 1'b1;
                    if (a_status == ST_BLOCKED)
                    begin
                        status_next[idx_reg] = ST_READY;
                        if (rcnt_reg < cnt_t'(MAX_THREADS))
                        begin
                            rfifo_next[tail] = idx_reg;
                            rcnt_next        = rcnt_reg + cnt_t'(1);
                        end
                        code_next = RES_OK;
                    end
                end
            end
            OP_DISP:
            begin
                idx_next = '0;
                if (cur_reg != IDLE_SLOT)
                begin
                    case (disp_reg)
                        DISP_SLEEP:
                        begin
                            wake_next[cur_reg]   = now_reg + ticks_reg;
                            status_next[cur_reg] = ST_SLEEPING;
                        end
                        DISP_BLOCK: status_next[cur_reg] = ST_BLOCKED;
                        DISP_EXIT:  status_next[cur_reg] = ST_ZOMBIE;
                        default:    status_next[cur_reg] = status_reg[cur_reg];
                    endcase
                end
            end
            OP_ZOMBIE:
            begin
                idx_next = idx_reg + slot_t'(1);
                if (a_status == ST_ZOMBIE && idx_reg != cur_reg)
                begin
                    status_next[idx_reg] = ST_FREE;
                    id_next[idx_reg]     = '0;
                    wake_next[idx_reg]   = '0;
                end
            end
            OP_PICK:
            begin
                if (rcnt_reg == '0)
                    pick = (a_status == ST_RUNNING) ? cur_reg : IDLE_SLOT;
                else
                begin
                    pick      = rfifo_reg[head_reg];
                    head_next = wrap_add(head_reg, cnt_t'(1));
                    rcnt_next = rcnt_reg - cnt_t'(1);
                end
                nxt_next    = pick;
                switch_next = (pick != cur_reg);
            end
            OP_LEAVE:
            begin
                if (cur_reg == IDLE_SLOT)
                    status_next[cur_reg] = ST_READY;
                else if (a_status == ST_RUNNING)
                begin
                    status_next[cur_reg] = ST_READY;
                    if (rcnt_reg < cnt_t'(MAX_THREADS))
                    begin
                        rfifo_next[tail] = cur_reg;
                        rcnt_next        = rcnt_reg + cnt_t'(1);
                    end
                end
                else if (a_status == ST_SLEEPING)
                begin
                    if (scnt_reg < cnt_t'(MAX_THREADS))
                    begin
                        slist_next[scnt_reg[SLOT_W-1:0]] = cur_reg;
                        scnt_next = scnt_reg + cnt_t'(1);
                    end
                end
            end
            OP_ENTER:
            begin
                status_next[nxt_reg] = ST_RUNNING;
                cur_next             = nxt_reg;
                run_id_next          = a_id;
            end
            OP_TICK_INIT:
            begin
                idx_next   = SLOT_W'(scnt_reg - cnt_t'(1));
                wmask_next = '0;
                kept_next  = '0;
            end
            OP_WAKE:
            begin
                if (a_wake <= now_reg)
                begin
                    status_next[addr] = ST_READY;
                    if (rcnt_reg < cnt_t'(MAX_THREADS))
                    begin
                        rfifo_next[tail] = addr;
                        rcnt_next        = rcnt_reg + cnt_t'(1);
                    end
                    woken_next          = woken_reg + WOKEN_W'(1);
                    wmask_next[idx_reg] = 1'b1;
                end
                if (idx_reg != '0)
                    idx_next = idx_reg - slot_t'(1);
            end
            OP_COMPACT:
            begin
                idx_next = idx_reg + slot_t'(1);
                if (!wmask_reg[idx_reg])
                begin
                    slist_next[kept_reg[SLOT_W-1:0]] = slist_reg[idx_reg];
                    kept_next = kept_reg + cnt_t'(1);
                end
                if (stat.idx_top)
                    scnt_next = kept_next;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    assign stat.hit         = hit;
    assign stat.idx_zero    = (idx_reg == '0);
    assign stat.idx_max     = (idx_reg == slot_t'(MAX_THREADS - 1));
    assign stat.idx_top     = ({1'b0, idx_reg} + cnt_t'(1) == scnt_reg);
    assign stat.switch_flag = switch_reg;
    assign stat.sleep_empty = (scnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_THREADS; i++)
            begin
                status_reg[i] <= ST_FREE;
                id_reg[i]     <= '0;
                wake_reg[i]   <= '0;
            end
            status_reg[0]         <= ST_RUNNING;
            status_reg[IDLE_SLOT] <= ST_READY;
            id_reg[IDLE_SLOT]     <= id_t'(1);
            wmask_reg   <= '0;
            head_reg    <= '0;
            rcnt_reg    <= '0;
            scnt_reg    <= '0;
            kept_reg    <= '0;
            cur_reg     <= '0;
            nxt_reg     <= '0;
            switch_reg  <= 1'b0;
            idx_reg     <= '0;
            next_id_reg <= id_t'(2);
            run_id_reg  <= '0;
        end
        else
        begin
            status_reg  <= status_next;
            id_reg      <= id_next;
            wake_reg    <= wake_next;
            wmask_reg   <= wmask_next;
            head_reg    <= head_next;
            rcnt_reg    <= rcnt_next;
            scnt_reg    <= scnt_next;
            kept_reg    <= kept_next;
            cur_reg     <= cur_next;
            nxt_reg     <= nxt_next;
            switch_reg  <= switch_next;
            idx_reg     <= idx_next;
            next_id_reg <= next_id_next;
            run_id_reg  <= run_id_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rfifo_reg <= rfifo_next;
        slist_reg <= slist_next;
        code_reg  <= code_next;
        tid_reg   <= tid_next;
        woken_reg <= woken_next;
        if (cmd.op == OP_LOAD)
        begin
            act_reg    <= action;
            target_reg <= target_id;
            disp_reg   <= disposition;
            ticks_reg  <= sleep_ticks;
            now_reg    <= now_ticks;
        end
        if (cmd.op == OP_OUT)
        begin
            res_code_reg  <= code_reg;
            res_tid_reg   <= tid_reg;
            res_run_reg   <= run_id_reg;
            res_woken_reg <= (act_reg == ACT_TICK) ? woken_reg : '0;
        end
    end

    assign result_code = res_code_reg;
    assign thread_id   = res_tid_reg;
    assign running_id  = res_run_reg;
    assign woken_count = res_woken_reg;

endmodule
`default_nettype wire

// ----- sv/trss_ctrl.sv -----
// scheduler controller: sequences one item through the datapath
`timescale 1ns / 1ps
`default_nettype none
module trss_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire logic [1:0]      action,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output trss_pkg::cmd_t       cmd,
    input  wire trss_pkg::stat_t stat
);
    import trss_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CREATE    = 4'd1;
    localparam logic [3:0] S_UNBLOCK   = 4'd2;
    localparam logic [3:0] S_DISP      = 4'd3;
    localparam logic [3:0] S_ZOMBIE    = 4'd4;
    localparam logic [3:0] S_PICK      = 4'd5;
    localparam logic [3:0] S_LEAVE     = 4'd6;
    localparam logic [3:0] S_ENTER     = 4'd7;
    localparam logic [3:0] S_TICK_INIT = 4'd8;
    localparam logic [3:0] S_WAKE      = 4'd9;
    localparam logic [3:0] S_COMPACT   = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    case (action)
                        ACT_CREATE:   state_next = S_CREATE;
                        ACT_UNBLOCK:  state_next = S_UNBLOCK;
                        ACT_SCHEDULE: state_next = S_DISP;
                        default:      state_next = S_TICK_INIT;
                    endcase
                end
            end
            S_CREATE:
            begin
                cmd.op = OP_CREATE;
                if (stat.hit || stat.idx_max)
                    state_next = S_DONE;
            end
            S_UNBLOCK:
            begin
                cmd.op = OP_UNBLOCK;
                if (stat.hit || stat.idx_max)
                    state_next = S_DONE;
            end
            S_DISP:
            begin
                cmd.op     = OP_DISP;
                state_next = S_ZOMBIE;
            end
            S_ZOMBIE:
            begin
                cmd.op = OP_ZOMBIE;
                if (stat.idx_max)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.op     = OP_PICK;
                state_next = S_LEAVE;
            end
            S_LEAVE:
            begin
                if (stat.switch_flag)
                begin
                    cmd.op     = OP_LEAVE;
                    state_next = S_ENTER;
                end
                else
                    state_next = S_DONE;
            end
            S_ENTER:
            begin
                cmd.op     = OP_ENTER;
                state_next = S_DONE;
            end
            S_TICK_INIT:
            begin
                cmd.op     = OP_TICK_INIT;
                state_next = stat.sleep_empty ? S_DONE : S_WAKE;
            end
            S_WAKE:
            begin
                cmd.op = OP_WAKE;
                if (stat.idx_zero)
                    state_next = S_COMPACT;
            end
            S_COMPACT:
            begin
                cmd.op = OP_COMPACT;
                if (stat.idx_top)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

// ----- sv/thread_ready_sleep_scheduler_core.sv -----
// top level of the round-robin thread scheduler with sleep queue
// usage:
// - input channel in_valid/in_ready carries one beat per request: action,
//   target_id, disposition, sleep_ticks, now_ticks
// - output channel out_valid/out_ready carries one result beat per request:
//   result_code, thread_id, running_id, woken_count
// - one request at a time; the slot table is walked one slot per cycle
// - create / unblock: the slot search walks the table until a hit or the last slot
// - schedule: disposition, zombie sweep over all 16 slots, pick, then leave and enter on a switch
// - tick: an init step plus two passes over the sleep list (wake, then compact)
// - a new request is taken while the previous result beat still waits
// - if the receiver stalls, the finished result waits inside until the
//   output register frees, and no further request is taken until then
// - after reset: slot 0 (id 0) runs, slot 1 is the idle thread (id 1),
//   the next created id is 2, ready and sleep queues are empty
`timescale 1ns / 1ps
`default_nettype none
module thread_ready_sleep_scheduler_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] target_id,
    input  wire logic [1:0]  disposition,
    input  wire logic [31:0] sleep_ticks,
    input  wire logic [31:0] now_ticks,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       result_code,
    output logic [31:0]      thread_id,
    output logic [31:0]      running_id,
    output logic [6:0]       woken_count
);
    import trss_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    trss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    trss_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .target_id   (target_id),
        .disposition (disposition),
        .sleep_ticks (sleep_ticks),
        .now_ticks   (now_ticks),
        .result_code (result_code),
        .thread_id   (thread_id),
        .running_id  (running_id),
        .woken_count (woken_count)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while busy");

    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (result_code == RES_OK || result_code == RES_FULL
                       || result_code == RES_BADID))
        else $error("illegal result code");

    a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_code != RES_OK) |-> (thread_id == '0))
        else $error("failed request reports a thread id");

    a_woken_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (woken_count <= 7'(MAX_THREADS)))
        else $error("woken count exceeds slot count");

endmodule
`default_nettype wire

// ----- verif/sched_checker.sv -----
// checker for the thread scheduler: predicts each result beat and compares it
`timescale 1ns / 1ps
`default_nettype none
module sched_checker
    import trss_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [1:0]  action,
    input  wire logic [31:0] target_id,
    input  wire logic [1:0]  disposition,
    input  wire logic [31:0] sleep_ticks,
    input  wire logic [31:0] now_ticks,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [1:0]  result_code,
    input  wire logic [31:0] thread_id,
    input  wire logic [31:0] running_id,
    input  wire logic [6:0]  woken_count,
    output int               fail_count,
    output int               pending
);

    typedef struct {
        logic [1:0]  code;
        logic [31:0] tid;
        logic [31:0] rid;
        logic [6:0]  woken;
    } sched_result_t;

    sched_result_t result_q[$];

    id_t     tbl_id[MAX_THREADS];
    status_t tbl_st[MAX_THREADS];
    id_t     tbl_wake[MAX_THREADS];
    int      ready_q[$];
    int      sleep_q[$];
    int      run_slot;
    id_t     id_next;

    assign pending = result_q.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("mismatch %s: got %0h expected %0h", what, got, want);
            fail_count++;
        end
    endtask

    function automatic void push_ready(input int s);
        if (ready_q.size() < MAX_THREADS)
            ready_q.push_back(s);
    endfunction

    function automatic sched_result_t predict_result(input logic [1:0] act, input id_t tgt,
                                                     input logic [1:0] disp, input id_t ticks,
                                                     input id_t now);
        sched_result_t r;
        int cur;
        int nxt;
        int keep[$];
        begin
            r.code = RES_OK;
            r.tid = '0;
            r.woken = '0;
            if (act == ACT_CREATE) begin
                r.code = RES_FULL;
                for (int i = 0; i < MAX_THREADS; i++) begin
                    if (tbl_st[i] == ST_FREE) begin
                        tbl_id[i] = id_next;
                        tbl_st[i] = ST_READY;
                        tbl_wake[i] = '0;
                        push_ready(i);
                        r.tid = id_next;
                        id_next++;
                        r.code = RES_OK;
                        break;
                    end
                end
            end else if (act == ACT_UNBLOCK) begin
                r.code = RES_BADID;
                for (int i = 0; i < MAX_THREADS; i++) begin
                    if (tbl_st[i] != ST_FREE && tbl_id[i] == tgt) begin
                        if (tbl_st[i] == ST_BLOCKED) begin
                            tbl_st[i] = ST_READY;
                            push_ready(i);
                            r.code = RES_OK;
                        end
                        break;
                    end
                end
            end else if (act == ACT_SCHEDULE) begin
                cur = run_slot;
                if (cur != IDLE_SLOT) begin
                    if (disp == DISP_SLEEP) begin
                        tbl_wake[cur] = now + ticks;
                        tbl_st[cur] = ST_SLEEPING;
                    end else if (disp == DISP_BLOCK) begin
                        tbl_st[cur] = ST_BLOCKED;
                    end else if (disp == DISP_EXIT) begin
                        tbl_st[cur] = ST_ZOMBIE;
                    end
                end
                for (int i = 0; i < MAX_THREADS; i++) begin
                    if (tbl_st[i] == ST_ZOMBIE && i != cur) begin
                        tbl_st[i] = ST_FREE;
                        tbl_id[i] = '0;
                        tbl_wake[i] = '0;
                    end
                end
                if (ready_q.size() == 0)
                    nxt = (tbl_st[cur] == ST_RUNNING) ? cur : IDLE_SLOT;
                else
                    nxt = ready_q.pop_front();
                if (nxt != cur) begin
                    if (cur == IDLE_SLOT) begin
                        tbl_st[cur] = ST_READY;
                    end else if (tbl_st[cur] == ST_RUNNING) begin
                        tbl_st[cur] = ST_READY;
                        push_ready(cur);
                    end else if (tbl_st[cur] == ST_SLEEPING) begin
                        if (sleep_q.size() < MAX_THREADS)
                            sleep_q.push_back(cur);
                    end
                    tbl_st[nxt] = ST_RUNNING;
                    run_slot = nxt;
                end
            end else begin
                for (int i = sleep_q.size() - 1; i >= 0; i--) begin
                    if (tbl_wake[sleep_q[i]] <= now) begin
                        tbl_st[sleep_q[i]] = ST_READY;
                        push_ready(sleep_q[i]);
                        r.woken++;
                    end
                end
                foreach (sleep_q[i])
                    if (!(tbl_wake[sleep_q[i]] <= now))
                        keep.push_back(sleep_q[i]);
                sleep_q = keep;
            end
            r.rid = tbl_id[run_slot];
            return r;
        end
    endfunction

    initial
    begin
        fail_count = 0;
        for (int i = 0; i < MAX_THREADS; i++)
        begin
            tbl_id[i] = '0;
            tbl_st[i] = ST_FREE;
            tbl_wake[i] = '0;
        end
        tbl_st[0] = ST_RUNNING;
        tbl_id[IDLE_SLOT] = 1;
        tbl_st[IDLE_SLOT] = ST_READY;
        run_slot = 0;
        id_next = 2;
    end

    always @(posedge clk)
    begin
        sched_result_t w;
        if (rst_n) begin
            if (in_valid && in_ready)
                result_q.push_back(predict_result(action, target_id, disposition,
                                                  sleep_ticks, now_ticks));
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    report("unexpected beat", '0, '0);
                end else begin
                    w = result_q.pop_front();
                    if (result_code !== w.code) report("result_code", result_code, w.code);
                    if (thread_id !== w.tid) report("thread_id", thread_id, w.tid);
                    if (running_id !== w.rid) report("running_id", running_id, w.rid);
                    if (woken_count !== w.woken)
                        report("woken_count", woken_count, w.woken);
                end
            end
        end
    end

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// testbench top: drives requests to the thread scheduler and gives the verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import trss_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  action;
    logic [31:0] target_id;
    logic [1:0]  disposition;
    logic [31:0] sleep_ticks;
    logic [31:0] now_ticks;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_code;
    logic [31:0] thread_id;
    logic [31:0] running_id;
    logic [6:0]  woken_count;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic [31:0] sys_now;
    logic [31:0] last_id;

    thread_ready_sleep_scheduler_core dut (.*);

    sched_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // receiver with random stalls
    initial
    begin
        int stall;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    task automatic send_req(input logic [1:0] act, input logic [31:0] tgt, input logic [1:0] disp,
                            input logic [31:0] ticks, input logic [31:0] now);
        begin
            in_valid <= 1;
            action <= act;
            target_id <= tgt;
            disposition <= disp;
            sleep_ticks <= ticks;
            now_ticks <= now;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            if (act == ACT_CREATE && thread_id == 0) last_id <= last_id;
        end
    endtask

    task automatic gap();
        int n;
        begin
            n = $urandom_range(0, 5);
            if (n > 0)
            begin
                in_valid <= 0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    task automatic rand_req(input bit wide);
        logic [1:0] act;
        logic [31:0] tgt;
        logic [31:0] ticks;
        begin
            act = 2'($urandom_range(0, 3));
            tgt = wide ? $urandom : $urandom_range(0, 40);
            ticks = wide ? $urandom : $urandom_range(0, 30);
            sys_now = sys_now + $urandom_range(0, 8);
            if (wide && $urandom_range(0, 3) == 0) sys_now = $urandom;
            send_req(act, tgt, 2'($urandom_range(0, 3)), ticks, sys_now);
        end
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        action = ACT_CREATE;
        target_id = 0;
        disposition = DISP_YIELD;
        sleep_ticks = 0;
        now_ticks = 0;
        sys_now = 0;
        last_id = 0;
        idle_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: fill table, overflow, every disposition, unblocks, ticks
        for (int i = 0; i < 15; i++) send_req(ACT_CREATE, 0, DISP_YIELD, 0, 0);
        send_req(ACT_UNBLOCK, 32'hffffffff, DISP_YIELD, 0, 0);
        send_req(ACT_SCHEDULE, 0, DISP_BLOCK, 0, 0);
        send_req(ACT_UNBLOCK, 0, DISP_YIELD, 0, 0);
        send_req(ACT_SCHEDULE, 0, DISP_SLEEP, 32'hffffffff, 32'hffffffff);
        send_req(ACT_SCHEDULE, 0, DISP_SLEEP, 0, 5);
        send_req(ACT_SCHEDULE, 0, DISP_EXIT, 0, 0);
        send_req(ACT_TICK, 0, DISP_YIELD, 0, 32'hffffffff);
        send_req(ACT_SCHEDULE, 0, DISP_YIELD, 0, 0);
        send_req(ACT_TICK, 0, DISP_YIELD, 0, 0);
        send_req(ACT_CREATE, 0, DISP_YIELD, 0, 0);
        for (int n = 0; n < 2000; n++)
        begin
            gap();
            rand_req(n % 10 == 0);
            if (n == 1000)
            begin
                in_valid <= 0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end
        in_valid <= 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
`default_nettype wire
